// ----- hdl/trial_division_prime_test_assert.svh -----
// Assertion macros shared by the primality test modules.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Plain property checked at every clock edge outside reset.
`define TDPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define TDPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tdpt_pkg.sv -----
// Shared types and constants of the trial division primality test.
`default_nettype none
package tdpt_pkg;

  localparam int unsigned CAND_W      = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Class decided by the front end for each candidate.
  typedef enum logic [1:0] {
    CLS_NOT_PRIME,
    CLS_PRIME,
    CLS_TRIAL
  } cls_e;

  localparam int unsigned CLS_W = $bits(cls_e);

  // Status of the remainder unit towards the sequencer.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_sts_t;

endpackage
`default_nettype wire

// ----- hdl/tdpt_if.sv -----
// Stream interfaces for candidates in and verdicts out.
`default_nettype none
interface tdpt_cand_if;
  logic                         valid;
  logic                         ready;
  logic [tdpt_pkg::CAND_W-1:0]  candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_res_if;
  logic                         valid;
  logic                         ready;
  logic                         is_prime;
  logic [tdpt_pkg::COUNT_W-1:0] primes_found;

  modport source (output valid, output is_prime, output primes_found, input ready);
  modport sink   (input valid, input is_prime, input primes_found, output ready);
endinterface
`default_nettype wire

// ----- hdl/tdpt_front.sv -----
// Front end: takes candidate beats, masks them and sorts out the trivial cases.
`default_nettype none
module tdpt_front #(
  parameter int unsigned NW = 32
) (
  tdpt_cand_if.sink         cand_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output logic [NW-1:0]     q_num_o,
  output tdpt_pkg::cls_e    q_cls_o
);
  import tdpt_pkg::*;

  logic [NW-1:0] num;

  assign num          = cand_i.candidate[NW-1:0];
  assign cand_i.ready = !q_full_i;
  assign q_push_o     = cand_i.valid && !q_full_i;
  assign q_num_o      = num;

  // Zero and one are never prime; two and three have no divisor to try.
  always_comb begin
    priority if (num < NW'(2)) begin
      q_cls_o = CLS_NOT_PRIME;
    end else if (num < NW'(4)) begin
      q_cls_o = CLS_PRIME;
    end else begin
      q_cls_o = CLS_TRIAL;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tdpt_queue.sv -----
// Short first-in first-out queue between the front end and the sequencer.
`default_nettype none
`include "trial_division_prime_test_assert.svh"
module tdpt_queue #(
  parameter int unsigned DW = 34
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] rdata_o
);
  import tdpt_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  `TDPT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(QUEUE_DEPTH), "queue overfilled")
  `TDPT_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, full_o, !push_i, "push into a full queue")

endmodule
`default_nettype wire

// ----- hdl/tdpt_rem_unit.sv -----
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module tdpt_rem_unit #(
  parameter int unsigned NW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NW-1:0]      dividend_i,
  input  logic [NW-1:0]      divisor_i,
  output tdpt_pkg::rem_sts_t sts_o
);
  import tdpt_pkg::*;

  localparam int unsigned CW = $clog2(NW);

  logic          busy_q, done_q, zero_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] rem_q, dvd_q, dsr_q;
  logic [NW:0]   trial, diff;
  logic [NW-1:0] rem_d;

  // The partial remainder stays below the divisor, so one extra bit is enough.
  assign trial = {rem_q, dvd_q[NW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign rem_d = diff[NW] ? trial[NW-1:0] : diff[NW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(NW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[NW-2:0], 1'b0};
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          zero_q <= (rem_d == '0);
        end
      end
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.zero = zero_q;

endmodule
`default_nettype wire

// ----- hdl/tdpt_back.sv -----
// Sequencer: runs the divisor loop, keeps the prime count and holds the result beat.
`default_nettype none
`include "trial_division_prime_test_assert.svh"
module tdpt_back #(
  parameter int unsigned NW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  logic [NW-1:0]      q_num_i,
  input  tdpt_pkg::cls_e     q_cls_i,
  output logic               q_pop_o,
  output logic               rem_start_o,
  output logic [NW-1:0]      rem_dividend_o,
  output logic [NW-1:0]      rem_divisor_o,
  input  tdpt_pkg::rem_sts_t rem_sts_i,
  tdpt_res_if.source         res_o
);
  import tdpt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e             state_q;
  logic [NW-1:0]      num_q, div_q;
  logic [NW:0]        sq_q;
  logic               prime_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q, out_prime_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_free, out_load, past_root;

  assign q_pop_o        = (state_q == ST_IDLE) && q_valid_i;
  assign out_free       = !out_valid_q || res_o.ready;
  assign out_load       = (state_q == ST_FINISH) && out_free;
  // sq_q tracks the square of the current divisor.
  assign past_root      = (sq_q > {1'b0, num_q});
  assign rem_start_o    = (state_q == ST_CHECK) && !past_root;
  assign rem_dividend_o = num_q;
  assign rem_divisor_o  = div_q;
  assign count_d        = (prime_q && (count_q != '1)) ? count_q + COUNT_W'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= '0;
      div_q       <= '0;
      sq_q        <= '0;
      prime_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_prime_q <= 1'b0;
      out_count_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_prime_q <= prime_q;
        out_count_q <= count_d;
        count_q     <= count_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            num_q   <= q_num_i;
            div_q   <= NW'(2);
            sq_q    <= (NW + 1)'(4);
            prime_q <= (q_cls_i == CLS_PRIME);
            state_q <= (q_cls_i == CLS_TRIAL) ? ST_CHECK : ST_FINISH;
          end
        end
        ST_CHECK: begin
          if (past_root) begin
            prime_q <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (rem_sts_i.done) begin
            if (rem_sts_i.zero) begin
              prime_q <= 1'b0;
              state_q <= ST_FINISH;
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              sq_q    <= sq_q + {div_q, 1'b1};
              div_q   <= div_q + NW'(1);
              state_q <= ST_CHECK;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.is_prime     = out_prime_q;
  assign res_o.primes_found = out_count_q;

  `TDPT_ASSERT_NEXT(a_count_mono, clk_i, rst_ni, 1'b1, count_q >= $past(count_q), "count fell")
  `TDPT_ASSERT_IMP(a_done_in_divide, clk_i, rst_ni, rem_sts_i.done, state_q == ST_DIVIDE, "stray remainder")

endmodule
`default_nettype wire

// ----- hdl/trial_division_prime_test.sv -----
// Top level of the trial division primality test with a running prime count.
// Each candidate beat yields one result beat carrying the verdict and the prime count
// including that candidate; the count saturates at all ones. Candidates below four are
// settled by the front end. Larger ones are tried against divisors 2, 3, 4 and so on while
// the divisor squared does not exceed the candidate; every divisor passes a check state and
// then the bit-serial remainder unit on NW bits, where NW is the smaller of NUM_WIDTH and
// 32. A composite stops at its least divisor; a prime stops once the divisor squared
// exceeds it. A two-beat queue lets the front end keep taking candidates while the sequencer
// is busy, and a result register lets the next item start while a result beat waits to be
// taken.
`default_nettype none
module trial_division_prime_test #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdpt_cand_if.sink   cand_i,
  tdpt_res_if.source  res_o
);
  import tdpt_pkg::*;

  localparam int unsigned NW = (NUM_WIDTH < CAND_W) ? NUM_WIDTH : CAND_W;
  localparam int unsigned QW = NW + CLS_W;

  logic          q_push, q_full, q_pop, q_valid;
  logic [NW-1:0] f_num;
  cls_e          f_cls;
  logic [QW-1:0] q_rdata;
  logic          rem_start;
  logic [NW-1:0] rem_dividend, rem_divisor;
  rem_sts_t      rem_sts;

  tdpt_front #(.NW(NW)) u_front (
    .cand_i   (cand_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_num_o  (f_num),
    .q_cls_o  (f_cls)
  );

  tdpt_queue #(.DW(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_cls, f_num}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  tdpt_rem_unit #(.NW(NW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (rem_divisor),
    .sts_o      (rem_sts)
  );

  tdpt_back #(.NW(NW)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_num_i        (q_rdata[NW-1:0]),
    .q_cls_i        (cls_e'(q_rdata[QW-1:NW])),
    .q_pop_o        (q_pop),
    .rem_start_o    (rem_start),
    .rem_dividend_o (rem_dividend),
    .rem_divisor_o  (rem_divisor),
    .rem_sts_i      (rem_sts),
    .res_o          (res_o)
  );

endmodule
`default_nettype wire
